>>> rtl/lgbr_pkg.sv
package lgbr_pkg;

  localparam int unsigned LED_COUNT_DEF    = 24;
  localparam int unsigned SHIFT_CENTER_DEF = 12;

  localparam logic [63:0] PATTERN_RST      = 64'h1F_FE00;
  localparam logic [15:0] PERIOD_BASE_RST  = 16'd6000;
  localparam logic [7:0]  TICK_INC_RST     = 8'd51;
  localparam logic [9:0]  SHIFT_DIV_RST    = 10'd42;
  localparam logic [9:0]  SPEED_DIV_RST    = 10'd69;
  localparam logic [7:0]  SHIFT_STEP_RST   = 8'd10;
  localparam logic [7:0]  SPEED_STEP_RST   = 8'd17;
  localparam logic [15:0] BLINK_PERIOD_RST = 16'd6000;
  localparam logic [4:0]  SHIFT_SET_RST    = 5'd12;
  localparam logic [3:0]  SPEED_SET_RST    = 4'd1;

  localparam logic [4:0]  SHIFT_MAX = 5'd31;
  localparam logic [3:0]  SPEED_MAX = 4'd15;
  localparam logic [7:0]  PWM_MAX   = 8'd255;

  localparam logic [7:0]  SEG_MINUS = 8'h40;
  localparam logic [7:0]  SEG_H     = 8'h76;
  localparam logic [7:0]  SEG_P     = 8'h73;
  localparam logic [7:0]  SEG_POINT = 8'h80;
  localparam logic [7:0]  SEG_BLANK = 8'h00;

  localparam logic [7:0] HEX_SEG [16] = '{
    8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07,
    8'h7f, 8'h6f, 8'h77, 8'h7c, 8'h39, 8'h5e, 8'h79, 8'h71
  };

  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_MODE   = 2'd1,
    KIND_SELECT = 2'd2,
    KIND_KNOB   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    CFG_PERIOD_BASE = 3'd0,
    CFG_TICK_INC    = 3'd1,
    CFG_SHIFT_DIV   = 3'd2,
    CFG_SPEED_DIV   = 3'd3,
    CFG_SHIFT_STEP  = 3'd4,
    CFG_SPEED_STEP  = 3'd5
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_PDIV,
    ST_ROT,
    ST_DONE
  } state_e;

  function automatic logic [7:0] hex_code(input logic [5:0] v);
    logic [3:0] idx;
    idx = (v > 6'd15) ? 4'd15 : v[3:0];
    return HEX_SEG[idx];
  endfunction

endpackage

>>> rtl/led_garland_blink_rotate_controller.sv
// LED garland blink and rotate controller.
// Input channel: a word carries kind_i (tick, mode button, select button or
// knob sample) and knob_sample_i, taken when in_valid_i and in_ready_o are high.
// Output channel: every input word gives exactly one result word, held in an
// output register until out_valid_o and out_ready_i are both high.
// Configuration: cfg_index_i selects a register, cfg_data_i carries its value;
// cfg_ready_o is always high and writes are expected only while idle.
// One word is processed at a time. A mode, select or plain tick word goes
// straight to ST_DONE, which loads its result into the output register; no new
// word is taken until that result is loaded. A tick that relights the garland
// first rotates the pattern in ST_ROT by up to 19 positions, one position per
// cycle. A knob sample in settings mode passes ST_DIV, where a shared restoring
// divider produces one quotient bit per cycle, and ST_MUL, where a shift-add
// multiplier handles one setting bit per cycle; for speed, ST_PDIV then divides
// the base period by the new setting to give the blink period.
// The next word is accepted while a finished result still waits, so a stalled
// receiver holds back the block only once a second result is ready.
// Reset restores state, configuration, settings and the pattern to defaults.
module led_garland_blink_rotate_controller #(
  parameter int unsigned LED_COUNT    = lgbr_pkg::LED_COUNT_DEF,
  parameter int unsigned SHIFT_CENTER = lgbr_pkg::SHIFT_CENTER_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [9:0]  knob_sample_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [23:0] led_pattern_o,
  output logic        garland_lit_o,
  output logic        settings_active_o,
  output logic [7:0]  digit_letter_o,
  output logic [7:0]  digit_value_o,
  output logic [7:0]  digit_extra_o,
  output logic [7:0]  pwm_inverse_o,
  output logic [7:0]  pwm_direct_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import lgbr_pkg::*;

  localparam logic [5:0] CENTER = 6'(SHIFT_CENTER);

  state_e state_q, state_d;

  logic [15:0] period_base_q;
  logic [7:0]  tick_inc_q;
  logic [9:0]  shift_div_q, speed_div_q;
  logic [7:0]  shift_step_q, speed_step_q;

  logic                 settings_q, select_speed_q, lit_q;
  logic [LED_COUNT-1:0] pattern_q;
  logic [15:0]          counter_q, period_q;
  logic [4:0]           shift_set_q;
  logic [3:0]           speed_set_q;
  logic [7:0]           pwm_inv_q, pwm_dir_q;

  logic [15:0] dvd_q;
  logic [9:0]  rem_q, dvs_q;
  logic [3:0]  cnt_q;
  logic [4:0]  mpl_q;
  logic [12:0] mcd_q, acc_q;
  logic [5:0]  rot_q;
  logic        rot_left_q;

  logic        out_valid_q;
  logic [23:0] led_q;
  logic        lit_out_q, settings_out_q;
  logic [7:0]  letter_q, value_q, extra_q, pwm_inv_out_q, pwm_dir_out_q;

  logic        accept, out_load;
  logic [16:0] tick_sum;
  logic [15:0] tick_sat;
  logic        tick_flip;
  logic [5:0]  shift_ext, rot_amt;
  logic        rot_left;
  logic [10:0] trial;
  logic        trial_ge;
  logic [9:0]  rem_next;
  logic [15:0] quo_next;
  logic [4:0]  h_sat;
  logic [3:0]  p_sat;
  logic [63:0] pattern_ext;
  logic [7:0]  letter_c, value_c, extra_c;

  assign tick_sum  = {1'b0, counter_q} + {9'b0, tick_inc_q};
  assign tick_sat  = tick_sum[16] ? 16'hFFFF : tick_sum[15:0];
  assign tick_flip = tick_sat >= period_q;

  assign shift_ext = {1'b0, shift_set_q};
  assign rot_left  = shift_ext >= CENTER;
  assign rot_amt   = rot_left ? (shift_ext - CENTER) : (CENTER - shift_ext);

  assign trial    = {rem_q, dvd_q[15]};
  assign trial_ge = trial >= {1'b0, dvs_q};
  assign rem_next = trial_ge ? 10'(trial - {1'b0, dvs_q}) : trial[9:0];
  assign quo_next = {dvd_q[14:0], trial_ge};
  assign h_sat    = (|quo_next[15:5]) ? SHIFT_MAX : quo_next[4:0];
  assign p_sat    = (quo_next >= 16'd15) ? SPEED_MAX : 4'(quo_next[3:0] + 4'd1);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_DONE;
          if (kind_i == KIND_TICK) begin
            if (!settings_q && tick_flip && !lit_q && rot_amt != 6'd0) begin
              state_d = ST_ROT;
            end
          end else if (kind_i == KIND_KNOB && settings_q) begin
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (cnt_q == 4'd15) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        if (mpl_q == 5'd0) begin
          state_d = select_speed_q ? ST_PDIV : ST_DONE;
        end
      end
      ST_PDIV: begin
        if (cnt_q == 4'd15) begin
          state_d = ST_DONE;
        end
      end
      ST_ROT: begin
        if (rot_q == 6'd1) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    in_ready_o = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_DONE: out_load = !out_valid_q || out_ready_i;
      default: begin
        in_ready_o = 1'b0;
        out_load   = 1'b0;
      end
    endcase
  end

  assign accept      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_base_q <= PERIOD_BASE_RST;
      tick_inc_q    <= TICK_INC_RST;
      shift_div_q   <= SHIFT_DIV_RST;
      speed_div_q   <= SPEED_DIV_RST;
      shift_step_q  <= SHIFT_STEP_RST;
      speed_step_q  <= SPEED_STEP_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_PERIOD_BASE: period_base_q <= cfg_data_i;
        CFG_TICK_INC:    tick_inc_q    <= cfg_data_i[7:0];
        CFG_SHIFT_DIV:   shift_div_q   <= cfg_data_i[9:0];
        CFG_SPEED_DIV:   speed_div_q   <= cfg_data_i[9:0];
        CFG_SHIFT_STEP:  shift_step_q  <= cfg_data_i[7:0];
        CFG_SPEED_STEP:  speed_step_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settings_q     <= 1'b0;
      select_speed_q <= 1'b1;
      lit_q          <= 1'b1;
      pattern_q      <= PATTERN_RST[LED_COUNT-1:0];
      counter_q      <= '0;
      period_q       <= BLINK_PERIOD_RST;
      shift_set_q    <= SHIFT_SET_RST;
      speed_set_q    <= SPEED_SET_RST;
      pwm_inv_q      <= '0;
      pwm_dir_q      <= '0;
      cnt_q          <= '0;
      rot_q          <= '0;
      rot_left_q     <= 1'b0;
      mpl_q          <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            cnt_q <= '0;
            case (kind_i)
              KIND_TICK: begin
                if (!settings_q) begin
                  if (tick_flip) begin
                    counter_q  <= '0;
                    lit_q      <= !lit_q;
                    rot_q      <= rot_amt;
                    rot_left_q <= rot_left;
                  end else begin
                    counter_q <= tick_sat;
                  end
                end
              end
              KIND_MODE: settings_q <= !settings_q;
              KIND_SELECT: begin
                if (settings_q) begin
                  select_speed_q <= !select_speed_q;
                end
              end
              default: ;
            endcase
          end
        end
        ST_DIV: begin
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == 4'd15) begin
            if (select_speed_q) begin
              speed_set_q <= p_sat;
              mpl_q       <= {1'b0, p_sat};
            end else begin
              shift_set_q <= h_sat;
              mpl_q       <= h_sat;
            end
          end
        end
        ST_MUL: begin
          mpl_q <= mpl_q >> 1;
          cnt_q <= '0;
          if (mpl_q == 5'd0) begin
            pwm_dir_q <= (|acc_q[12:8]) ? PWM_MAX : acc_q[7:0];
            pwm_inv_q <= (|acc_q[12:8]) ? 8'd0 : 8'(PWM_MAX - acc_q[7:0]);
          end
        end
        ST_PDIV: begin
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == 4'd15) begin
            period_q <= quo_next;
          end
        end
        ST_ROT: begin
          rot_q <= rot_q - 6'd1;
          if (rot_left_q) begin
            pattern_q <= {pattern_q[LED_COUNT-2:0], pattern_q[LED_COUNT-1]};
          end else begin
            pattern_q <= {pattern_q[0], pattern_q[LED_COUNT-1:1]};
          end
        end
        default: ;
      endcase
    end
  end

  // Shared divider and multiplier datapath.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        dvd_q <= {6'b0, knob_sample_i};
        rem_q <= '0;
        if (select_speed_q) begin
          dvs_q <= (speed_div_q == 10'd0) ? 10'd1 : speed_div_q;
        end else begin
          dvs_q <= (shift_div_q == 10'd0) ? 10'd1 : shift_div_q;
        end
      end
      ST_DIV: begin
        dvd_q <= quo_next;
        rem_q <= rem_next;
        acc_q <= '0;
        mcd_q <= select_speed_q ? {5'b0, speed_step_q} : {5'b0, shift_step_q};
      end
      ST_MUL: begin
        if (mpl_q[0]) begin
          acc_q <= acc_q + mcd_q;
        end
        mcd_q <= mcd_q << 1;
        dvd_q <= period_base_q;
        rem_q <= '0;
        dvs_q <= {6'b0, speed_set_q};
      end
      ST_PDIV: begin
        dvd_q <= quo_next;
        rem_q <= rem_next;
      end
      default: ;
    endcase
  end

  assign pattern_ext = 64'(pattern_q);

  always_comb begin
    extra_c = SEG_BLANK;
    if (!select_speed_q) begin
      letter_c = SEG_H | SEG_POINT;
      if (shift_ext < CENTER) begin
        value_c = SEG_MINUS;
        extra_c = hex_code(CENTER - shift_ext);
      end else begin
        value_c = hex_code(shift_ext - CENTER);
      end
    end else begin
      letter_c = SEG_P | SEG_POINT;
      value_c  = hex_code({2'b0, speed_set_q});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      led_q          <= lit_q ? pattern_ext[23:0] : 24'd0;
      lit_out_q      <= lit_q;
      settings_out_q <= settings_q;
      letter_q       <= letter_c;
      value_q        <= value_c;
      extra_q        <= extra_c;
      pwm_inv_out_q  <= pwm_inv_q;
      pwm_dir_out_q  <= pwm_dir_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign led_pattern_o     = led_q;
  assign garland_lit_o     = lit_out_q;
  assign settings_active_o = settings_out_q;
  assign digit_letter_o    = letter_q;
  assign digit_value_o     = value_q;
  assign digit_extra_o     = extra_q;
  assign pwm_inverse_o     = pwm_inv_out_q;
  assign pwm_direct_o      = pwm_dir_out_q;

endmodule

>>> rtl/lgbr_checker.sv
module lgbr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [23:0] led_pattern_o,
  input logic        garland_lit_o,
  input logic [7:0]  digit_letter_o,
  input logic [7:0]  digit_value_o,
  input logic [7:0]  digit_extra_o,
  input logic [7:0]  pwm_inverse_o,
  input logic [7:0]  pwm_direct_o
);
  import lgbr_pkg::*;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(led_pattern_o))
    else $error("Stalled result word changed.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !garland_lit_o |-> led_pattern_o == 24'd0)
    else $error("Dark garland shows a pattern.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> digit_letter_o == (SEG_H | SEG_POINT)
                 || digit_letter_o == (SEG_P | SEG_POINT))
    else $error("Unknown mode letter.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && digit_extra_o != SEG_BLANK |->
      digit_value_o == SEG_MINUS && digit_letter_o == (SEG_H | SEG_POINT))
    else $error("Extra digit shown without a negative shift.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (9'(pwm_inverse_o) + 9'(pwm_direct_o) == 9'(PWM_MAX))
                 || (pwm_inverse_o == 8'd0 && pwm_direct_o == 8'd0))
    else $error("PWM levels are not complementary.");

endmodule

bind led_garland_blink_rotate_controller lgbr_checker u_lgbr_checker (.*);
